### sv/hrc_pkg.sv
`default_nettype none
package hrc_pkg;

  typedef struct packed {
    logic        action;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] address;
    logic [4:0]  pc_low;
    logic        hit;
  } item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_value;
    logic       streaming;
  } result_t;

  typedef struct packed {
    logic        action;
    logic [15:0] set;
    logic [4:0]  way;
    logic [63:0] addr;
    logic [4:0]  pc;
    logic        hit;
    logic [11:0] sig;
  } cmd_t;

  typedef struct packed {
    logic [10:0]       leader_sets;
    logic signed [2:0] stream_threshold;
    logic [15:0]       decay_interval;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_WALK
  } state_t;

  localparam logic [1:0] CFG_LEADER_SETS      = 2'd0;
  localparam logic [1:0] CFG_STREAM_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_DECAY_INTERVAL   = 2'd2;

  localparam logic        ACT_VICTIM   = 1'b0;
  localparam logic [63:0] STRIDE_POS   = 64'd64;
  localparam logic [63:0] STRIDE_NEG   = 64'hFFFF_FFFF_FFFF_FFC0;
  localparam logic [1:0]  RR_DISTANT   = 2'd3;
  localparam logic [1:0]  RR_LONG      = 2'd2;
  localparam logic [1:0]  RR_NEAR      = 2'd0;
  localparam logic [1:0]  CNT_MAX      = 2'd3;
  localparam logic [1:0]  SIG_CNT_INIT = 2'd1;

  localparam logic [10:0] LEADER_SETS_RST    = 11'd32;
  localparam logic [2:0]  STREAM_THRESH_RST  = 3'd2;
  localparam logic [15:0] DECAY_INTERVAL_RST = 16'd8192;

endpackage
`default_nettype wire

### sv/hrc_front.sv
`default_nettype none
module hrc_front import hrc_pkg::*; #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIGNATURE_BITS = 5
) (
  input  wire logic  start,
  input  wire logic  busy,
  input  wire item_t item,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [15:0] SET_MASK = 16'(NUM_SETS - 1);
  localparam logic [4:0]  WAY_MASK = 5'(NUM_WAYS - 1);
  localparam logic [11:0] SIG_MASK = 12'((1 << SIGNATURE_BITS) - 1);

  assign push = start && !busy;

  always_comb begin
    cmd.action = item.action;
    cmd.set    = {5'b0, item.set_index} & SET_MASK;
    cmd.way    = {1'b0, item.way_index} & WAY_MASK;
    cmd.addr   = item.address;
    cmd.pc     = item.pc_low;
    cmd.hit    = item.hit;
    cmd.sig    = ({7'b0, item.pc_low} ^ item.address[17:6]) & SIG_MASK;
  end

endmodule
`default_nettype wire

### sv/hrc_queue.sv
`default_nettype none
module hrc_queue import hrc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty,
  output logic      full
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout  = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### sv/hrc_back.sv
`default_nettype none
module hrc_back import hrc_pkg::*; #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIGNATURE_BITS = 5,
  parameter int SELECTOR_BITS  = 10
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire cmd_t  q_head,
  output logic       pop,
  output logic       done,
  output result_t    result,
  output back_status_t status
);

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int SB    = SIGNATURE_BITS;
  localparam int SIG_N = 1 << SB;
  localparam int SLB   = SELECTOR_BITS;
  localparam logic [SLB-1:0]   SEL_MID  = SLB'(1 << (SLB - 1));
  localparam logic [SLB-1:0]   SEL_MAX  = '1;
  localparam logic [SET_W:0]   CNT_END  = (SET_W + 1)'(NUM_SETS);
  localparam logic [SET_W:0]   CNT_LAST = (SET_W + 1)'(NUM_SETS - 1);

  logic [NUM_WAYS-1:0][1:0]    rr_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][SB-1:0] ls_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][1:0]    dc_mem [NUM_SETS];
  logic [63:0]                 la_mem [NUM_SETS];
  logic [2:0]                  ss_mem [NUM_SETS];

  logic [NUM_WAYS-1:0][1:0]    rr_q, rr_wd;
  logic [NUM_WAYS-1:0][SB-1:0] ls_q, ls_wd;
  logic [NUM_WAYS-1:0][1:0]    dc_q, dc_wd;
  logic [63:0]                 la_q, la_wd;
  logic [2:0]                  ss_q, ss_wd;
  logic                        rr_we, ls_we, dc_we, meta_we;
  logic [SET_W-1:0]            rd_addr, wa, dc_wa;

  state_t              state, state_next;
  logic [SET_W:0]      cnt;
  cmd_t                cur;
  logic [SIG_N-1:0][1:0] sigcnt;
  logic [SLB-1:0]      psel, psel_next;
  logic [15:0]         upd_cnt;
  logic                decay;
  logic [1:0]          dead_t;
  logic signed [2:0]   score_t;
  logic                done_next;
  result_t             result_next;

  logic [SET_W-1:0]  cur_set;
  logic [WAY_W-1:0]  cur_way;
  logic [SB-1:0]     cur_sig;
  logic [SB-1:0]     old_sig;
  logic [63:0]       delta;
  logic              stride, moved;
  logic signed [2:0] ss_old, score_new;
  logic [16:0]       period, cnt_inc;
  logic              decay_hit;
  logic [1:0]        dead_train;
  logic              any3, any2, any1;
  logic [1:0]        top, add;
  logic [WAY_W-1:0]  best;
  logic [1:0]        sc_raw, sc, dc;
  logic [16:0]       set17;
  logic              lip_lead, bip_lead, use_lip, streaming;
  logic [4:0]        px;
  logic [1:0]        ins;

  assign cur_set = cur.set[SET_W-1:0];
  assign cur_way = cur.way[WAY_W-1:0];
  assign cur_sig = cur.sig[SB-1:0];
  assign status.clearing = (state == ST_CLEAR);
  assign pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rr_we) begin
      rr_mem[wa] <= rr_wd;
    end
    rr_q <= rr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[wa] <= ls_wd;
    end
    ls_q <= ls_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dc_we) begin
      dc_mem[dc_wa] <= dc_wd;
    end
    dc_q <= dc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      la_mem[wa] <= la_wd;
      ss_mem[wa] <= ss_wd;
    end
    la_q <= la_mem[rd_addr];
    ss_q <= ss_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (cur.action == ACT_VICTIM) ? ST_IDLE : ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = decay ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        if (cnt == CNT_END) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    delta     = cur.addr - la_q;
    stride    = (delta == STRIDE_POS) || (delta == STRIDE_NEG);
    moved     = (delta != 64'd0);
    ss_old    = $signed(ss_q);
    score_new = ss_old;
    if (stride) begin
      if (ss_old != 3'sd3) begin
        score_new = ss_old + 3'sd1;
      end
    end else if (moved) begin
      if (ss_old != -3'sd4) begin
        score_new = ss_old - 3'sd1;
      end
    end
    old_sig    = ls_q[cur_way];
    dead_train = cur.hit ? 2'd0 :
                 (dc_q[cur_way] == CNT_MAX) ? CNT_MAX : dc_q[cur_way] + 2'd1;
    period     = (cfg.decay_interval == 16'd0) ? 17'h10000 : {1'b0, cfg.decay_interval};
    cnt_inc    = {1'b0, upd_cnt} + 17'd1;
    decay_hit  = (cnt_inc >= period);

    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rr_q[w] == 2'd3);
      any2 = any2 | (rr_q[w] == 2'd2);
      any1 = any1 | (rr_q[w] == 2'd1);
    end
    top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
    add = RR_DISTANT - top;
    best = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rr_q[w] == top) begin
        best = WAY_W'(w);
      end
    end

    sc_raw = sigcnt[cur_sig];
    sc     = (decay && sc_raw != 2'd0) ? sc_raw - 2'd1 : sc_raw;
    dc     = (decay && dead_t != 2'd0) ? dead_t - 2'd1 : dead_t;
    set17    = 17'(cur_set);
    lip_lead = set17 < {6'b0, cfg.leader_sets};
    bip_lead = !lip_lead && (set17 < {5'b0, cfg.leader_sets, 1'b0});
    use_lip  = lip_lead ? 1'b1 : bip_lead ? 1'b0 : (psel < SEL_MID);
    streaming = score_t >= cfg.stream_threshold;
    px = cur.pc ^ cur.addr[4:0];
    psel_next = psel;
    if (streaming) begin
      ins = (px[1:0] != 2'd0) ? RR_DISTANT : RR_LONG;
      if (bip_lead && !cur.hit && psel < SEL_MAX) begin
        psel_next = psel + 1'b1;
      end
    end else if (sc >= 2'd2 && dc <= 2'd1) begin
      ins = RR_NEAR;
      if (lip_lead && !cur.hit && psel != '0) begin
        psel_next = psel - 1'b1;
      end
    end else if (sc == 2'd1 || dc == 2'd2) begin
      ins = (use_lip || px != 5'd0) ? RR_LONG : RR_NEAR;
    end else begin
      ins = RR_LONG;
    end
  end

  always_comb begin
    rd_addr = cur_set;
    wa      = (state == ST_CLEAR) ? cnt[SET_W-1:0] : cur_set;
    dc_wa   = cur_set;
    rr_we   = 1'b0;
    ls_we   = 1'b0;
    dc_we   = 1'b0;
    meta_we = 1'b0;
    rr_wd   = rr_q;
    ls_wd   = ls_q;
    dc_wd   = dc_q;
    la_wd   = cur.addr;
    ss_wd   = score_new;
    done_next   = 1'b0;
    result_next = '0;
    case (state)
      ST_CLEAR: begin
        dc_wa   = cnt[SET_W-1:0];
        rr_we   = 1'b1;
        ls_we   = 1'b1;
        dc_we   = 1'b1;
        meta_we = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
          rr_wd[w] = RR_LONG;
        end
        ls_wd = '0;
        dc_wd = '0;
        la_wd = '0;
        ss_wd = '0;
      end
      ST_IDLE: begin
        rd_addr = q_head.set[SET_W-1:0];
      end
      ST_READ: begin
        if (cur.action == ACT_VICTIM) begin
          rr_we = 1'b1;
          for (int w = 0; w < NUM_WAYS; w++) begin
            rr_wd[w] = rr_q[w] + add;
          end
          done_next = 1'b1;
          result_next.victim_way = 4'(best);
        end else begin
          meta_we = 1'b1;
        end
      end
      ST_DECIDE: begin
        rr_we = 1'b1;
        ls_we = 1'b1;
        dc_we = 1'b1;
        rr_wd[cur_way] = ins;
        ls_wd[cur_way] = cur_sig;
        dc_wd[cur_way] = dead_t;
        done_next = 1'b1;
        result_next.insert_value = ins;
        result_next.streaming    = streaming;
      end
      ST_WALK: begin
        rd_addr = cnt[SET_W-1:0];
        dc_wa   = SET_W'(cnt - 1'b1);
        dc_we   = (cnt != '0);
        for (int w = 0; w < NUM_WAYS; w++) begin
          dc_wd[w] = (dc_q[w] != 2'd0) ? dc_q[w] - 2'd1 : 2'd0;
        end
      end
      default: begin
        rd_addr = cur_set;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (pop) begin
      cur <= q_head;
    end
    if (state == ST_READ) begin
      dead_t  <= dead_train;
      score_t <= score_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      done    <= 1'b0;
      psel    <= SEL_MID;
      upd_cnt <= '0;
      decay   <= 1'b0;
      for (int i = 0; i < SIG_N; i++) begin
        sigcnt[i] <= SIG_CNT_INIT;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR || state == ST_WALK) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == ST_READ && cur.action != ACT_VICTIM) begin
        decay   <= decay_hit;
        upd_cnt <= decay_hit ? 16'd0 : cnt_inc[15:0];
        if (cur.hit) begin
          if (sigcnt[cur_sig] != CNT_MAX) begin
            sigcnt[cur_sig] <= sigcnt[cur_sig] + 2'd1;
          end
        end else if (sigcnt[old_sig] != 2'd0) begin
          sigcnt[old_sig] <= sigcnt[old_sig] - 2'd1;
        end
      end
      if (state == ST_DECIDE) begin
        psel <= psel_next;
        if (decay) begin
          for (int i = 0; i < SIG_N; i++) begin
            if (sigcnt[i] != 2'd0) begin
              sigcnt[i] <= sigcnt[i] - 2'd1;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/hybrid_rrip_cache_replacement.sv
// Replacement engine for a set-associative last-level cache. Raise start with an item while
// busy is low; the item is taken at that edge. Each item yields one result, shown for
// exactly one cycle with done high, in item order; the receiver cannot stall it. A victim
// request passes through the idle and read states, an update also through a decide state
// (one registered read of the set's metadata rows, then compute and write-back). Once per
// decay interval (register 2) of updates the update is followed by a walk over all NUM_SETS
// dead-counter rows, one row a cycle. After reset busy stays high for a clearing pass over
// all NUM_SETS rows. A two-entry queue takes items while the engine works; busy rises when
// it is full. Configuration is written with cfg_we.
`default_nettype none
module hybrid_rrip_cache_replacement import hrc_pkg::*; #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int SIGNATURE_BITS = 5,
  parameter int SELECTOR_BITS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t         cfg;
  cmd_t         cmd, q_head;
  logic         push, pop, q_empty, q_full;
  back_status_t status;

  assign busy = q_full || status.clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_sets      <= LEADER_SETS_RST;
      cfg.stream_threshold <= STREAM_THRESH_RST;
      cfg.decay_interval   <= DECAY_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEADER_SETS:      cfg.leader_sets      <= cfg_data[10:0];
        CFG_STREAM_THRESHOLD: cfg.stream_threshold <= cfg_data[2:0];
        CFG_DECAY_INTERVAL:   cfg.decay_interval   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hrc_front #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIGNATURE_BITS(SIGNATURE_BITS)
  ) u_front (
    .start(start), .busy(busy), .item(item), .push(push), .cmd(cmd)
  );

  hrc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(cmd), .pop(pop),
    .dout(q_head), .empty(q_empty), .full(q_full)
  );

  hrc_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .SIGNATURE_BITS(SIGNATURE_BITS), .SELECTOR_BITS(SELECTOR_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_head(q_head),
    .pop(pop), .done(done), .result(result), .status(status)
  );

endmodule
`default_nettype wire

### sv/hrc_checker.sv
`default_nettype none
module hrc_checker import hrc_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  assert property (@(posedge clk) rst |=> busy && !done)
    else $error("no clearing after reset");

  assert property (@(posedge clk) disable iff (rst) !done |-> result == '0)
    else $error("result not zero while idle");

  assert property (@(posedge clk) disable iff (rst)
    done && result.victim_way != 4'd0 |-> result.insert_value == 2'd0 && !result.streaming)
    else $error("victim result carries update fields");

  assert property (@(posedge clk) disable iff (rst)
    done && result.streaming |-> result.insert_value == 2'd2 || result.insert_value == 2'd3)
    else $error("streaming insert value out of set");

endmodule

bind hybrid_rrip_cache_replacement hrc_checker u_hrc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result)
);
`default_nettype wire

### tb/tb_hybrid_rrip_cache_replacement.sv
`timescale 1ns / 100ps
module tb_hybrid_rrip_cache_replacement;
  import hrc_pkg::*;

  localparam logic ACT_UPDATE = 1'b1;
  localparam int   SETS = 2048;
  localparam int   WAYS = 16;
  localparam int   SEL_MID = 512;
  localparam int   SEL_MAX = 1023;
  localparam int   WALK_PAUSE = 2200;
  localparam int   STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  hybrid_rrip_cache_replacement DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [1:0]        rrpv [SETS*WAYS];
  logic [4:0]        line_sig [SETS*WAYS];
  logic [1:0]        dead [SETS*WAYS];
  logic [1:0]        sig_ctr [32];
  logic [63:0]       prev_addr [SETS];
  logic signed [2:0] stream_cnt [SETS];
  int                psel;
  int                upd_count;
  int                leader_cnt;
  logic signed [2:0] stream_thresh;
  int                decay_len;

  result_t pending_results[$];
  int      fail_count = 0;
  int      stall_cycles = 0;
  int      idle_pct = 0;
  int      set_pool[8] = '{0, 5, 31, 40, 63, 100, 700, 2047};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void model_reset();
    for (int i = 0; i < SETS*WAYS; i++) begin
      rrpv[i] = RR_LONG;
      line_sig[i] = '0;
      dead[i] = '0;
    end
    for (int i = 0; i < 32; i++) sig_ctr[i] = SIG_CNT_INIT;
    for (int i = 0; i < SETS; i++) begin
      prev_addr[i] = '0;
      stream_cnt[i] = '0;
    end
    psel = SEL_MID;
    upd_count = 0;
    leader_cnt = LEADER_SETS_RST;
    stream_thresh = STREAM_THRESH_RST;
    decay_len = DECAY_INTERVAL_RST;
  endfunction

  function automatic result_t predict_replacement(item_t it);
    result_t r;
    int set, base, line, top, best, period, sig;
    logic [63:0] delta;
    logic lip_lead, bip_lead, use_lip, strm;
    logic [1:0] ins;
    r = '0;
    set = it.set_index;
    base = set * WAYS;
    if (it.action == ACT_VICTIM) begin
      top = 0;
      best = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (rrpv[base+w] > top) begin
          top = rrpv[base+w];
          best = w;
        end
      end
      if (top < 3)
        for (int w = 0; w < WAYS; w++) rrpv[base+w] = rrpv[base+w] + 2'(3 - top);
      r.victim_way = 4'(best);
      return r;
    end
    line = base + it.way_index;
    delta = it.address - prev_addr[set];
    if (delta == STRIDE_POS || delta == STRIDE_NEG) begin
      if (stream_cnt[set] < 3) stream_cnt[set] = stream_cnt[set] + 3'sd1;
    end else if (delta != 0) begin
      if (stream_cnt[set] > -4) stream_cnt[set] = stream_cnt[set] - 3'sd1;
    end
    prev_addr[set] = it.address;
    sig = it.pc_low ^ it.address[10:6];
    if (it.hit) begin
      if (sig_ctr[sig] < CNT_MAX) sig_ctr[sig]++;
      dead[line] = '0;
    end else begin
      if (sig_ctr[line_sig[line]] > 0) sig_ctr[line_sig[line]]--;
      if (dead[line] < CNT_MAX) dead[line]++;
    end
    period = (decay_len == 0) ? 65536 : decay_len;
    if (upd_count + 1 >= period) begin
      upd_count = 0;
      for (int i = 0; i < 32; i++) if (sig_ctr[i] > 0) sig_ctr[i]--;
      for (int i = 0; i < SETS*WAYS; i++) if (dead[i] > 0) dead[i]--;
    end else begin
      upd_count = upd_count + 1;
    end
    lip_lead = set < leader_cnt;
    bip_lead = !lip_lead && set < 2 * leader_cnt;
    use_lip = lip_lead ? 1'b1 : (bip_lead ? 1'b0 : (psel < SEL_MID));
    strm = stream_cnt[set] >= stream_thresh;
    if (strm) begin
      ins = ((it.pc_low[1:0] ^ it.address[1:0]) != 0) ? RR_DISTANT : RR_LONG;
      if (bip_lead && !it.hit && psel < SEL_MAX) psel++;
    end else if (sig_ctr[sig] >= 2 && dead[line] <= 1) begin
      ins = RR_NEAR;
      if (lip_lead && !it.hit && psel > 0) psel--;
    end else if (sig_ctr[sig] == 1 || dead[line] == 2) begin
      if (use_lip) ins = RR_LONG;
      else ins = ((it.pc_low ^ it.address[4:0]) != 0) ? RR_LONG : RR_NEAR;
    end else begin
      ins = RR_LONG;
    end
    rrpv[line] = ins;
    line_sig[line] = 5'(sig);
    r.insert_value = ins;
    r.streaming = strm;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("hybrid_rrip_cache_replacement regression: fail");
        $finish;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result %p", result);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (result.victim_way !== exp_r.victim_way) begin
            $error("victim_way expected %0d actual %0d", exp_r.victim_way, result.victim_way);
            fail_count++;
          end
          if (result.insert_value !== exp_r.insert_value) begin
            $error("insert_value expected %0d actual %0d", exp_r.insert_value,
                   result.insert_value);
            fail_count++;
          end
          if (result.streaming !== exp_r.streaming) begin
            $error("streaming expected %0d actual %0d", exp_r.streaming, result.streaming);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_item(item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_replacement(it));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (WALK_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEADER_SETS:      leader_cnt = val[10:0];
      CFG_STREAM_THRESHOLD: stream_thresh = val[2:0];
      default:              decay_len = val;
    endcase
    @(posedge clk);
  endtask

  function automatic item_t make_item(logic act, int set, int way, logic [63:0] addr,
                                      int pc, logic hit);
    item_t it;
    it.action = act;
    it.set_index = 11'(set);
    it.way_index = 4'(way);
    it.address = addr;
    it.pc_low = 5'(pc);
    it.hit = hit;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int set;
    logic [63:0] a;
    set = ($urandom_range(0, 9) < 7) ? set_pool[$urandom_range(0, 7)] : $urandom_range(0, 2047);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = prev_addr[set] + STRIDE_POS;
      4, 5:       a = prev_addr[set] + STRIDE_NEG;
      6:          a = prev_addr[set];
      default:    a = {$urandom, $urandom};
    endcase
    it = make_item(($urandom_range(0, 99) < 30) ? ACT_VICTIM : ACT_UPDATE, set,
                   $urandom_range(0, 15), a, $urandom_range(0, 31), $urandom_range(0, 1));
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_item(ACT_VICTIM, 0, 0, '0, 0, 1'b0));
    send_item(make_item(ACT_VICTIM, 2047, 15, '1, 31, 1'b1));
    send_item(make_item(ACT_UPDATE, 2047, 15, 64'hFFFF_FFFF_FFFF_FFC0, 31, 1'b0));
    send_item(make_item(ACT_UPDATE, 2047, 15, 64'hFFFF_FFFF_FFFF_FF80, 31, 1'b1));
    send_item(make_item(ACT_UPDATE, 2047, 0, 64'hFFFF_FFFF_FFFF_FFC0, 0, 1'b1));
    send_item(make_item(ACT_UPDATE, 2047, 3, 64'hFFFF_FFFF_FFFF_FFC0, 7, 1'b0));
    send_item(make_item(ACT_VICTIM, 2047, 0, '0, 0, 1'b0));
    send_item(make_item(ACT_UPDATE, 5, 1, 64'd64, 1, 1'b0));
    send_item(make_item(ACT_UPDATE, 5, 1, 64'd128, 1, 1'b0));
    send_item(make_item(ACT_UPDATE, 5, 2, 64'd192, 2, 1'b1));
    send_item(make_item(ACT_UPDATE, 5, 2, 64'h1234_5678_9ABC_DEF0, 2, 1'b0));
    send_item(make_item(ACT_UPDATE, 40, 9, 64'hAAAA_5555_AAAA_5555, 21, 1'b1));
    send_item(make_item(ACT_UPDATE, 40, 9, 64'h5555_AAAA_5555_AAAA, 10, 1'b1));
    send_item(make_item(ACT_UPDATE, 40, 9, 64'h5555_AAAA_5555_AAAA, 10, 1'b0));
    send_item(make_item(ACT_UPDATE, 1000, 4, 64'h0000_0000_0000_0020, 0, 1'b0));
    send_item(make_item(ACT_VICTIM, 5, 0, '0, 0, 1'b0));
    send_item(make_item(ACT_VICTIM, 5, 0, '0, 0, 1'b0));
    send_item(make_item(ACT_VICTIM, 40, 0, '0, 0, 1'b0));
    drain();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_item(random_item());
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_LEADER_SETS, 16'd0);
    write_reg(CFG_STREAM_THRESHOLD, 16'h0004);
    write_reg(CFG_DECAY_INTERVAL, 16'd65535);
    test_random(200, 57);
    write_reg(CFG_LEADER_SETS, 16'd1024);
    write_reg(CFG_STREAM_THRESHOLD, 16'h0003);
    write_reg(CFG_DECAY_INTERVAL, 16'd0);
    test_random(200, 26);
    write_reg(CFG_LEADER_SETS, 16'd3);
    write_reg(CFG_STREAM_THRESHOLD, 16'h0000);
    test_random(200, 0);
  endtask

  task automatic test_decay();
    write_reg(CFG_DECAY_INTERVAL, 16'd1);
    write_reg(CFG_LEADER_SETS, 16'd64);
    test_random(20, 57);
    write_reg(CFG_DECAY_INTERVAL, 16'd5);
    write_reg(CFG_STREAM_THRESHOLD, 16'h0002);
    test_random(150, 26);
    write_reg(CFG_DECAY_INTERVAL, 16'd8192);
    write_reg(CFG_LEADER_SETS, 16'd32);
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250, 0);
    test_config_sweep();
    test_decay();
    test_random(230, 57);
    if (fail_count == 0) begin
      $display("hybrid_rrip_cache_replacement regression: pass");
    end else begin
      $display("hybrid_rrip_cache_replacement regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/hrc_pkg.sv
sv/hrc_front.sv
sv/hrc_queue.sv
sv/hrc_back.sv
sv/hybrid_rrip_cache_replacement.sv
sv/hrc_checker.sv
tb/tb_hybrid_rrip_cache_replacement.sv
